>>> hdl/glb_pkg.sv
// Shared types and constants for the gap buffer line store.
// Depends on nothing; every other file in hdl imports it.
package glb_pkg;

	localparam int CAPACITY    = 1024;
	localparam int ENTRY_WIDTH = 32;
	localparam int DATA_W      = 32;
	localparam int ADDR_W      = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [ADDR_W-1:0]      addr_t;
	typedef logic [ENTRY_WIDTH-1:0] entry_t;
	typedef logic [DATA_W-1:0]      data_t;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		mode_t mode;
		cnt_t  position;
		cnt_t  count;
		data_t entry_value;
	} req_t;

	typedef struct packed {
		status_t status;
		cnt_t    total_lines;
		data_t   read_value;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic check;
		logic rd_load;
		logic mv_step;
		logic normalize;
		logic edit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		mode_t mode;
		logic  skip;
		logic  need_move;
	} dp_sts_t;

endpackage

>>> hdl/glb_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on glb_pkg for the payload types.
interface glb_req_if import glb_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface glb_rsp_if import glb_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> hdl/glb_datapath.sv
// Datapath: entry memory, run counters, range checks and the result register.
// Depends on glb_pkg; driven by glb_ctrl through dp_cmd_t.
module glb_datapath import glb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  req_t    req_data,
	input  dp_cmd_t cmd,
	output dp_sts_t sts,
	output rsp_t    rsp_data
);

	req_t    req_q;
	cnt_t    front_q;
	cnt_t    bstart_q;
	cnt_t    bcount_q;
	entry_t  mem [CAPACITY];
	entry_t  rdata_q;
	logic    wpend_s1;
	addr_t   wdst_s1;
	status_t res_status_q;
	data_t   res_value_q;

	cnt_t            total;
	logic [CNT_W:0]  span;
	status_t         chk_status;
	logic            mv_left;
	logic            mv_right;
	cnt_t            rd_off;
	addr_t           rd_addr;
	addr_t           raddr;
	addr_t           mv_waddr;
	logic            ins_wr;
	cnt_t            front_inc;

	assign total     = front_q + bcount_q;
	assign span      = {1'b0, req_q.position} + {1'b0, req_q.count};
	assign mv_left   = req_q.position < front_q;
	assign mv_right  = (req_q.position > front_q) && (bcount_q != '0);
	assign rd_off    = bstart_q + (req_q.position - front_q);
	assign rd_addr   = mv_left ? req_q.position[ADDR_W-1:0] : rd_off[ADDR_W-1:0];
	assign front_inc = front_q + cnt_t'(1);
	assign ins_wr    = cmd.edit && (req_q.mode == MODE_INSERT);

	always_comb begin
		chk_status = ST_OK;
		case (req_q.mode)
			MODE_INSERT: begin
				if (req_q.position > total)
					chk_status = ST_RANGE;
				else if (total >= cnt_t'(CAPACITY))
					chk_status = ST_FULL;
			end
			MODE_DELETE: begin
				if ((req_q.count != '0) &&
				    ((req_q.position >= total) || (span > {1'b0, total})))
					chk_status = ST_RANGE;
			end
			MODE_READ: begin
				if (req_q.position >= total)
					chk_status = ST_RANGE;
			end
			default: chk_status = ST_OK;
		endcase
	end

	// A read never moves the gap, so it always addresses the requested slot.
	always_comb begin
		if (req_q.mode == MODE_READ) begin
			raddr    = rd_addr;
			mv_waddr = front_q[ADDR_W-1:0];
		end else if (mv_left) begin
			raddr    = addr_t'(front_q - cnt_t'(1));
			mv_waddr = addr_t'(bstart_q - cnt_t'(1));
		end else if (mv_right) begin
			raddr    = bstart_q[ADDR_W-1:0];
			mv_waddr = front_q[ADDR_W-1:0];
		end else begin
			raddr    = rd_addr;
			mv_waddr = front_q[ADDR_W-1:0];
		end
	end

	assign sts.mode      = req_q.mode;
	assign sts.skip      = (chk_status != ST_OK) ||
	                       ((req_q.mode == MODE_DELETE) && (req_q.count == '0));
	assign sts.need_move = mv_left || mv_right;

	always_ff @(posedge clk) begin
		if (cmd.capture)
			req_q <= req_data;
	end

	// A gap move reads the source slot and writes it to the destination in the
	// next cycle, so one entry moves per cycle.
	always_ff @(posedge clk) begin
		if (wpend_s1)
			mem[wdst_s1] <= rdata_q;
		else if (ins_wr)
			mem[front_q[ADDR_W-1:0]] <= req_q.entry_value[ENTRY_WIDTH-1:0];
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		wdst_s1 <= mv_waddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpend_s1 <= 1'b0;
		end else begin
			wpend_s1 <= cmd.mv_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			bstart_q <= cnt_t'(CAPACITY);
			bcount_q <= '0;
		end else if (cmd.mv_step) begin
			if (mv_left) begin
				front_q  <= front_q - cnt_t'(1);
				bstart_q <= bstart_q - cnt_t'(1);
				bcount_q <= bcount_q + cnt_t'(1);
			end else begin
				front_q  <= front_inc;
				bstart_q <= bstart_q + cnt_t'(1);
				bcount_q <= bcount_q - cnt_t'(1);
			end
		end else if (cmd.normalize) begin
			if (bcount_q == '0)
				bstart_q <= cnt_t'(CAPACITY);
		end else if (cmd.edit) begin
			case (req_q.mode)
				MODE_INSERT: begin
					// When the gap closes, the back run joins the front run.
					if (front_inc == bstart_q) begin
						front_q  <= front_inc + bcount_q;
						bstart_q <= cnt_t'(CAPACITY);
						bcount_q <= '0;
					end else begin
						front_q <= front_inc;
					end
				end
				MODE_DELETE: begin
					if (bcount_q == req_q.count) begin
						bstart_q <= cnt_t'(CAPACITY);
						bcount_q <= '0;
					end else begin
						bstart_q <= bstart_q + req_q.count;
						bcount_q <= bcount_q - req_q.count;
					end
				end
				MODE_CLEAR: begin
					front_q  <= '0;
					bstart_q <= cnt_t'(CAPACITY);
					bcount_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			res_status_q <= chk_status;
			res_value_q  <= '0;
		end else if (cmd.rd_load) begin
			res_value_q <= data_t'(rdata_q);
		end
	end

	assign rsp_data.status      = res_status_q;
	assign rsp_data.total_lines = total;
	assign rsp_data.read_value  = res_value_q;

`ifndef ASSERT_OFF
	a_total_fits: assert property (@(posedge clk) disable iff (!arst_n)
		total <= cnt_t'(CAPACITY))
		else $error("entry total exceeds capacity");

	a_runs_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		front_q <= bstart_q)
		else $error("front run overlaps back run");

	a_back_fits: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, bstart_q} + {1'b0, bcount_q}) <= (CNT_W+1)'(CAPACITY))
		else $error("back run extends past the store");

	a_no_raw: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mv_step && wpend_s1) |-> (wdst_s1 != raddr))
		else $error("gap move reads a slot with a write still pending");

	a_ins_clean: assert property (@(posedge clk) disable iff (!arst_n)
		ins_wr |-> !wpend_s1)
		else $error("insert write collides with a gap move write");
`endif

endmodule

>>> hdl/glb_ctrl.sv
// Controller: sequences check, gap move, edit, read load and result transfer.
// Depends on glb_pkg; commands glb_datapath through dp_cmd_t.
module glb_ctrl import glb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	output logic    rsp_valid,
	input  logic    rsp_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_CHECK  = 7'b0000010,
		S_RDDONE = 7'b0000100,
		S_MOVE   = 7'b0001000,
		S_DRAIN  = 7'b0010000,
		S_EDIT   = 7'b0100000,
		S_RESP   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_RESP);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (sts.skip)
					state_d = S_RESP;
				else if (sts.mode == MODE_READ)
					state_d = S_RDDONE;
				else if (sts.mode == MODE_CLEAR)
					state_d = S_EDIT;
				else
					state_d = S_MOVE;
			end
			S_RDDONE: begin
				cmd.rd_load = 1'b1;
				state_d     = S_RESP;
			end
			S_MOVE: begin
				if (sts.need_move)
					cmd.mv_step = 1'b1;
				else
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				cmd.normalize = 1'b1;
				state_d       = S_EDIT;
			end
			S_EDIT: begin
				cmd.edit = 1'b1;
				state_d  = S_RESP;
			end
			S_RESP: begin
				if (rsp_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hdl/gap_buffer_line_store.sv
// Top level of the gap buffer line store: controller plus datapath.
// Depends on glb_pkg, glb_if, glb_ctrl and glb_datapath.
//
//   channel  direction  payload
//   req      in         mode, position, count, entry_value
//   rsp      out        status, total_lines, read_value
//
// Insert and delete first move the gap to the requested position; the single
// write port of the entry memory moves one entry per cycle across the gap.
// Read, clear and a rejected request move no entries. One request is handled
// at a time; req is ready only while no result is pending. After reset the
// list is empty and the memory needs no clearing. A stalled result holds on
// rsp until it is taken.
module gap_buffer_line_store import glb_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	glb_req_if.sink  req,
	glb_rsp_if.source rsp
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	glb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	glb_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req.data),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_data (rsp.data)
	);

endmodule

>>> verif/gap_buffer_line_store_checker.sv
// Reply checker for the gap buffer line store: mirrors the list of entries,
// predicts the reply to every request transfer and compares each reply transfer.
// Depends on glb_pkg and the channel interfaces in glb_if.
module gap_buffer_line_store_checker import glb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	glb_req_if          req,
	glb_rsp_if          rsp,
	output int unsigned mismatches,
	output int unsigned replies_due_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// The list in logical order; where the gap sits inside the block is not visible outside.
	entry_t lines_held[$];
	rsp_t   replies_due[$];
	rsp_t   want;

	function automatic rsp_t edit_lines(req_t r);
		rsp_t reply;
		int   total;
		int   pos;
		int   cnt;
		total = lines_held.size();
		pos = int'(r.position);
		cnt = int'(r.count);
		reply.status = ST_OK;
		reply.read_value = '0;
		case (r.mode)
			MODE_INSERT: begin
				// The position is checked before the fill level.
				if (pos > total)
					reply.status = ST_RANGE;
				else if (total >= CAPACITY)
					reply.status = ST_FULL;
				else
					lines_held.insert(pos, r.entry_value[ENTRY_WIDTH-1:0]);
			end
			MODE_DELETE: begin
				if (cnt != 0) begin
					if (pos >= total || pos + cnt > total)
						reply.status = ST_RANGE;
					else
						repeat (cnt) lines_held.delete(pos);
				end
			end
			MODE_CLEAR: begin
				lines_held.delete();
			end
			default: begin
				if (pos >= total)
					reply.status = ST_RANGE;
				else
					reply.read_value = data_t'(lines_held[pos]);
			end
		endcase
		reply.total_lines = cnt_t'(lines_held.size());
		return reply;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_held.delete();
			replies_due.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (replies_due.size() == 0) begin
					$display("%0t: reply with none due: status %0d lines %0d value %h",
						$time, rsp.data.status, rsp.data.total_lines, rsp.data.read_value);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					if (rsp.data.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp.data.status);
						mismatches++;
					end
					if (rsp.data.total_lines !== want.total_lines) begin
						$display("%0t: total_lines expected %0d actual %0d",
							$time, want.total_lines, rsp.data.total_lines);
						mismatches++;
					end
					if (rsp.data.read_value !== want.read_value) begin
						$display("%0t: read_value expected %h actual %h",
							$time, want.read_value, rsp.data.read_value);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready)
				replies_due.push_back(edit_lines(req.data));
		end
		replies_due_count = replies_due.size();
	end

endmodule

>>> verif/gap_buffer_line_store_tb.sv
// Testbench top for the gap buffer line store: clock, reset, request stimulus
// and reply stalls, with the reply checker beside the block.
// Depends on glb_pkg, glb_if, gap_buffer_line_store and its checker.
module gap_buffer_line_store_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import glb_pkg::*;

	localparam int RANDOM_ITEMS = 450;
	localparam int RUN_LIMIT    = 2_000_000;
	localparam int HOLD_AT      = 200;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 1100;

	logic        clk;
	logic        arst_n;
	int          lines_now;
	int          cycles;
	int unsigned requests_sent;
	int unsigned replies_taken;
	int unsigned mismatches;
	int unsigned replies_due_count;

	glb_req_if req_ch();
	glb_rsp_if rsp_ch();

	gap_buffer_line_store DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	gap_buffer_line_store_checker reply_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.req               (req_ch),
		.rsp               (rsp_ch),
		.mismatches        (mismatches),
		.replies_due_count (replies_due_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Offers one request and returns after its transfer. Valid stays high when
	// the next request follows with no gap.
	task automatic send_request(mode_t m, int p, int c, data_t v);
		int gap;
		gap = ((requests_sent / 48) % 4 == 3) ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= '{mode: m, position: cnt_t'(p), count: cnt_t'(c), entry_value: v};
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		requests_sent++;
		// Track the list length only to steer positions and counts.
		case (m)
			MODE_INSERT: begin
				if (p <= lines_now && lines_now < CAPACITY)
					lines_now++;
			end
			MODE_DELETE: begin
				if (c != 0 && p < lines_now && p + c <= lines_now)
					lines_now -= c;
			end
			MODE_CLEAR: begin
				lines_now = 0;
			end
			default: ;
		endcase
	endtask

	task automatic random_request();
		int pick;
		int ins_w;
		int del_w;
		int pos;
		int cnt;
		int span;
		pick = $urandom_range(0, 99);
		ins_w = (lines_now < 64) ? 45 : 25;
		del_w = (lines_now < 64) ? 20 : 40;
		pos = 0;
		cnt = 0;
		if (pick < 5) begin
			send_request(mode_t'($urandom_range(0, 3)), $urandom_range(0, 2047),
				$urandom_range(0, 2047), $urandom());
		end else if (pick < 7) begin
			send_request(MODE_CLEAR, $urandom_range(0, 2047), $urandom_range(0, 2047),
				$urandom());
		end else if (pick < 7 + ins_w) begin
			send_request(MODE_INSERT, $urandom_range(0, lines_now + 1),
				$urandom_range(0, 2047), $urandom());
		end else if (pick < 7 + ins_w + del_w) begin
			if (lines_now == 0) begin
				cnt = $urandom_range(0, 1);
			end else begin
				pos = $urandom_range(0, lines_now - 1);
				span = lines_now - pos;
				if (span > 6)
					span = 6;
				// One past the span runs off the end only where the span was not cut to six.
				cnt = $urandom_range(0, span + 1);
			end
			send_request(MODE_DELETE, pos, cnt, $urandom());
		end else begin
			send_request(MODE_READ, $urandom_range(0, lines_now), $urandom_range(0, 2047),
				$urandom());
		end
	endtask

	// Reply side: random stalls, a few stretches without stalls, and one long
	// hold-off that lets the block back up onto the request channel.
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		forever begin
			stall = ((replies_taken / 56) % 4 == 1) ? 0 : $urandom_range(0, 11);
			if (replies_taken == HOLD_AT)
				stall = HOLD_CYCLES;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			replies_taken++;
		end
	end

	initial begin
		cycles = 0;
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int i;
		lines_now = 0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list, bounds, both ends of the fields, every mode.
		send_request(MODE_READ, 0, 0, '0);
		send_request(MODE_DELETE, 0, 0, '0);
		send_request(MODE_DELETE, 0, 1, '0);
		send_request(MODE_INSERT, 1, 0, 32'h1234_5678);
		send_request(MODE_INSERT, 0, 0, 32'hFFFF_FFFF);
		send_request(MODE_INSERT, 0, 0, 32'h0000_0000);
		send_request(MODE_INSERT, 2, 0, 32'hA5A5_A5A5);
		send_request(MODE_INSERT, 1, 0, 32'h5A5A_5A5A);
		send_request(MODE_READ, 0, 0, '0);
		send_request(MODE_READ, 3, 0, '0);
		send_request(MODE_READ, 4, 0, '0);
		send_request(MODE_DELETE, 1, 2, '0);
		send_request(MODE_DELETE, 0, 3, '0);
		send_request(MODE_DELETE, 2047, 2047, '1);
		send_request(MODE_DELETE, 2047, 0, '0);
		send_request(MODE_INSERT, 2047, 2047, '1);
		send_request(MODE_READ, 2047, 2047, '1);
		send_request(MODE_DELETE, 1, 1, '0);
		send_request(MODE_READ, 0, 0, '0);
		send_request(MODE_CLEAR, 2047, 2047, '1);
		send_request(MODE_CLEAR, 0, 0, '0);
		send_request(MODE_INSERT, 0, 0, 32'hC0DE_0001);
		send_request(MODE_READ, 0, 0, '0);

		for (i = 0; i < RANDOM_ITEMS; i++)
			random_request();

		// Fill to one short of capacity by appending, then close the gap from
		// the middle, so the full and bounds checks meet a full store.
		send_request(MODE_CLEAR, 0, 0, '0);
		while (lines_now < CAPACITY - 1)
			send_request(MODE_INSERT, lines_now, 0, $urandom());
		send_request(MODE_INSERT, 511, 0, $urandom());
		send_request(MODE_INSERT, 300, 0, $urandom());
		send_request(MODE_INSERT, CAPACITY + 1, 0, $urandom());
		send_request(MODE_INSERT, CAPACITY, 0, $urandom());
		for (i = 0; i < 8; i++)
			send_request(MODE_READ, $urandom_range(0, CAPACITY - 1), 0, '0);
		send_request(MODE_READ, CAPACITY - 1, 0, '0);
		send_request(MODE_READ, CAPACITY, 0, '0);
		send_request(MODE_DELETE, 700, 0, '0);
		send_request(MODE_DELETE, CAPACITY - 1, 1, '0);
		send_request(MODE_INSERT, CAPACITY - 1, 0, $urandom());
		send_request(MODE_DELETE, 0, CAPACITY, '0);
		send_request(MODE_READ, 0, 0, '0);

		req_ch.valid <= 1'b0;
		wait (replies_taken == requests_sent);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && replies_due_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
